>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: sorted priority queue package
// Shared widths, codes and the per-cycle operation broadcast to the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned PRIO_W      = 64;
  localparam int unsigned PAYLOAD_W   = 32;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned STATUS_W    = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_IGNORE = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [PRIO_W-1:0] key;
  } cell_op_t;

endpackage

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on push it keeps, loads the new entry or takes its left
// neighbor; on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter bit          IS_HEAD      = 1'b0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_op_t                op_i,
  input  logic [PAYLOAD_BITS-1:0] data_i,
  input  logic                    left_go_i,
  input  logic                    left_valid_i,
  input  logic [PRIO_W-1:0]       left_prio_i,
  input  logic [PAYLOAD_BITS-1:0] left_payload_i,
  input  logic                    right_valid_i,
  input  logic [PRIO_W-1:0]       right_prio_i,
  input  logic [PAYLOAD_BITS-1:0] right_payload_i,
  output logic                    go_o,
  output logic                    valid_o,
  output logic [PRIO_W-1:0]       prio_o,
  output logic [PAYLOAD_BITS-1:0] payload_o
);

  logic                    valid_q, valid_d;
  logic [PRIO_W-1:0]       prio_q, prio_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic                    key_wins;

  // head yields only to a strictly higher key; later slots also on a tie
  always_comb begin
    if (IS_HEAD) begin
      key_wins = $signed(op_i.key) > $signed(prio_q);
    end else begin
      key_wins = $signed(op_i.key) >= $signed(prio_q);
    end
  end

  assign go_o = !valid_q || key_wins;

  always_comb begin
    valid_d   = valid_q;
    prio_d    = prio_q;
    payload_d = payload_q;
    if (op_i.push && go_o) begin
      if (IS_HEAD || !left_go_i) begin
        valid_d   = 1'b1;
        prio_d    = op_i.key;
        payload_d = data_i;
      end else begin
        valid_d   = left_valid_i;
        prio_d    = left_prio_i;
        payload_d = left_payload_i;
      end
    end else if (op_i.pop) begin
      valid_d   = right_valid_i;
      prio_d    = right_prio_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q    <= prio_d;
    payload_q <= payload_d;
  end

  assign valid_o   = valid_q;
  assign prio_o    = prio_q;
  assign payload_o = payload_q;

endmodule

>>> rtl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded max-first priority queue
// Systolic sorted chain of CAPACITY cells with one result per command.
// ----------------------------------------------------------------------------
// A command is taken on every cycle that start is high; busy stays low, so
// push, pop and peek may follow each other in consecutive cycles. Each
// command gives exactly one result, on the result ports in the cycle after
// the command, marked by result_valid_o for that single cycle; the receiver
// cannot stall it. Every cell compares the broadcast key in parallel and
// shifts with its neighbors in the same cycle. A push onto a full queue
// returns status full and changes nothing; pop or peek on an empty queue
// returns status empty.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [PRIO_W-1:0]    priority_req_i,
  input  logic [PAYLOAD_W-1:0] payload_i,
  output logic                 result_valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [PAYLOAD_W-1:0] head_payload_o,
  output logic [COUNT_W-1:0]   entry_count_o,
  output logic                 is_empty_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]                  count_q, count_d;
  logic                              result_valid_q;
  status_e                           status_q, status_d;
  logic [PAYLOAD_W-1:0]              head_q, head_d;
  logic [COUNT_W-1:0]                count_out_q;
  logic                              empty_q;

  cell_op_t                          op;
  logic [PAYLOAD_BITS-1:0]           data;
  logic [PAYLOAD_BITS+PAYLOAD_W-1:0] data_ext;
  logic [PAYLOAD_BITS+PAYLOAD_W-1:0] head_ext;
  logic [CNT_W+COUNT_W-1:0]          count_ext;
  logic                              full, empty, take;
  action_e                           action;

  logic                    go    [CAPACITY];
  logic                    valid [CAPACITY];
  logic [PRIO_W-1:0]       prio  [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay   [CAPACITY];

  assign busy     = 1'b0;
  assign take     = start && !busy;
  assign action   = action_e'(action_i);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign data_ext = {{PAYLOAD_BITS{1'b0}}, payload_i};
  assign data     = data_ext[PAYLOAD_BITS-1:0];
  assign head_ext = {{PAYLOAD_W{1'b0}}, pay[0]};

  always_comb begin
    op.push  = 1'b0;
    op.pop   = 1'b0;
    op.key   = priority_req_i;
    count_d  = count_q;
    status_d = ST_OK;
    head_d   = '0;
    if (take) begin
      unique case (action)
        ACT_PUSH: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            op.push = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        ACT_POP, ACT_PEEK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            head_d = head_ext[PAYLOAD_W-1:0];
            if (action == ACT_POP) begin
              op.pop  = 1'b1;
              count_d = count_q - 1'b1;
            end
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_d};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    l_go, l_valid, r_valid;
    logic [PRIO_W-1:0]       l_prio, r_prio;
    logic [PAYLOAD_BITS-1:0] l_pay, r_pay;

    if (i == 0) begin : g_left_edge
      assign l_go    = 1'b0;
      assign l_valid = 1'b0;
      assign l_prio  = '0;
      assign l_pay   = '0;
    end else begin : g_left
      assign l_go    = go[i-1];
      assign l_valid = valid[i-1];
      assign l_prio  = prio[i-1];
      assign l_pay   = pay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_edge
      assign r_valid = 1'b0;
      assign r_prio  = '0;
      assign r_pay   = '0;
    end else begin : g_right
      assign r_valid = valid[i+1];
      assign r_prio  = prio[i+1];
      assign r_pay   = pay[i+1];
    end

    spq_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .IS_HEAD      (i == 0)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .op_i            (op),
      .data_i          (data),
      .left_go_i       (l_go),
      .left_valid_i    (l_valid),
      .left_prio_i     (l_prio),
      .left_payload_i  (l_pay),
      .right_valid_i   (r_valid),
      .right_prio_i    (r_prio),
      .right_payload_i (r_pay),
      .go_o            (go[i]),
      .valid_o         (valid[i]),
      .prio_o          (prio[i]),
      .payload_o       (pay[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      count_q        <= count_d;
      result_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    head_q      <= head_d;
    count_out_q <= count_ext[COUNT_W-1:0];
    empty_q     <= (count_d == '0);
  end

  assign result_valid_o = result_valid_q;
  assign status_o       = status_q;
  assign head_payload_o = head_q;
  assign entry_count_o  = count_out_q;
  assign is_empty_o     = empty_q;

endmodule
